[hw/rtl/avsfp_pkg.sv]
package avsfp_pkg;

  localparam int unsigned PtsW   = 40;
  localparam int unsigned TickW  = 32;
  localparam int unsigned PlayW  = 10;
  localparam int unsigned DelayW = 17;
  localparam int unsigned ThrW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 64;

  localparam logic [TickW-1:0] StaleMs = TickW'(2000);
  localparam logic [ThrW-1:0]  DiffMinRst = ThrW'(100);
  localparam logic [ThrW-1:0]  DiffMaxRst = ThrW'(2000);

  typedef enum logic [CfgIdxW-1:0] {
    REG_SYNC_MODE = 2'd0,
    REG_DIFF_MIN  = 2'd1,
    REG_DIFF_MAX  = 2'd2,
    REG_UNUSED    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_VIDEO = 1'b0,
    OP_AUDIO = 1'b1
  } op_e;

  typedef struct packed {
    logic            sync_mode;
    logic [ThrW-1:0] diff_min;
    logic [ThrW-1:0] diff_max;
  } cfg_t;

  typedef struct packed {
    op_e              operation;
    logic [PtsW-1:0]  pts;
    logic [TickW-1:0] now;
    logic [PlayW-1:0] play;
  } in_item_t;

  typedef struct packed {
    logic [DelayW-1:0] delay;
    logic              drop;
    logic [PtsW-1:0]   other_pts;
    logic              audio_present;
  } out_item_t;

endpackage

[hw/rtl/avsfp_cfg_regs.sv]
module avsfp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [avsfp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [avsfp_pkg::ThrW-1:0]    cfg_data_i,
  output avsfp_pkg::cfg_t               cfg_o
);
  import avsfp_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SYNC_MODE: cfg_d.sync_mode = cfg_data_i[0];
        REG_DIFF_MIN:  cfg_d.diff_min  = cfg_data_i;
        REG_DIFF_MAX:  cfg_d.diff_max  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_mode <= 1'b0;
      cfg_q.diff_min  <= DiffMinRst;
      cfg_q.diff_max  <= DiffMaxRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/avsfp_in_reg.sv]
module avsfp_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  avsfp_pkg::in_item_t  in_item_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output avsfp_pkg::in_item_t  item_o
);
  import avsfp_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     push;

  assign in_ready_o = !valid_q || pop_i;
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (push) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[hw/rtl/avsfp_decide.sv]
module avsfp_decide (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  avsfp_pkg::in_item_t  item_i,
  input  avsfp_pkg::cfg_t      cfg_i,
  output avsfp_pkg::out_item_t result_o
);
  import avsfp_pkg::*;

  localparam int unsigned SW = PtsW + 2;

  logic [PtsW-1:0]  video_pts_q, video_pts_d;
  logic [PtsW-1:0]  audio_pts_q, audio_pts_d;
  logic [TickW-1:0] audio_tick_q, audio_tick_d;
  logic [TickW-1:0] free_tick_q, free_tick_d;

  logic signed [SW-1:0] diff_v, step, av, neg_av, free_d, v, dmin_s, dmax_s;
  logic [TickW-1:0]     since_audio, since_free;
  logic                 stale, free_ok, step_pos;
  logic [6:0]           x2;
  logic [15:0]          prod;
  logic signed [10:0]   base;
  logic signed [11:0]   quarter, half, stretch;
  logic [DelayW-1:0]    delay_video, delay_fresh, delay_free, delay_audio;
  logic                 drop_audio;

  assign diff_v = $signed({2'b00, item_i.pts}) - $signed({2'b00, video_pts_q});
  assign step   = (video_pts_q != '0) ? diff_v : '0;
  assign av     = $signed({2'b00, audio_pts_q}) - $signed({2'b00, item_i.pts});
  assign neg_av = -av;
  assign dmin_s = $signed({(SW-ThrW)'(0), cfg_i.diff_min});
  assign dmax_s = $signed({(SW-ThrW)'(0), cfg_i.diff_max});

  assign since_audio = item_i.now - audio_tick_q;
  assign since_free  = item_i.now - free_tick_q;
  assign stale       = (audio_pts_q == '0) || (since_audio > StaleMs);

  assign free_d  = diff_v - $signed({(SW-TickW)'(0), since_free});
  assign free_ok = (free_tick_q != '0) && !free_d[SW-1] && (free_d != '0) &&
                   (video_pts_q != '0) && (item_i.pts != video_pts_q);

  always_comb begin
    delay_free = '0;
    if (free_ok) begin
      if (|free_d[SW-1:ThrW]) begin
        delay_free = {1'b0, {ThrW{1'b1}}};
      end else begin
        delay_free = {1'b0, free_d[ThrW-1:0]};
      end
    end
  end

  // step*2/3 for step below 60: multiply twice the step by 171/512
  assign step_pos = !step[SW-1] && (step != '0);
  assign x2       = {step[5:0], 1'b0};
  assign prod     = 16'(x2) * 16'd171;

  always_comb begin
    delay_fresh = '0;
    if (!av[SW-1]) begin
      if (av > dmin_s) begin
        if (step_pos) begin
          delay_fresh = (step >= 42'sd40) ? DelayW'(20) : DelayW'(step[5:1]);
        end
      end else if (step_pos) begin
        delay_fresh = (step >= 42'sd60) ? DelayW'(40) : DelayW'(prod[15:9]);
      end
    end else if (neg_av >= dmax_s) begin
      delay_fresh = {1'b0, cfg_i.diff_max};
    end else begin
      delay_fresh = {1'b0, neg_av[ThrW-1:0]};
    end
  end

  always_comb begin
    delay_video = '0;
    if (!cfg_i.sync_mode) begin
      delay_video = stale ? delay_free : delay_fresh;
    end
  end

  assign v       = $signed({2'b00, video_pts_q}) - $signed({2'b00, item_i.pts});
  assign base    = 11'sd39 - $signed({1'b0, item_i.play});
  assign quarter = (12'(base) + (base[10] ? 12'sd3 : 12'sd0)) >>> 2;
  assign half    = (12'(base) + (base[10] ? 12'sd1 : 12'sd0)) >>> 1;

  always_comb begin
    drop_audio  = 1'b0;
    stretch     = '0;
    if (cfg_i.sync_mode) begin
      if (v > dmin_s) begin
        drop_audio = 1'b1;
      end else if (v < -dmin_s) begin
        if (v > -dmax_s) begin
          stretch = 12'(base) + quarter;
        end else begin
          stretch = 12'(base) + half;
        end
      end
    end
    delay_audio = DelayW'(stretch);
  end

  always_comb begin
    result_o = '0;
    unique case (item_i.operation)
      OP_VIDEO: begin
        result_o.delay         = delay_video;
        result_o.other_pts     = audio_pts_q;
        result_o.audio_present = !cfg_i.sync_mode && !stale;
      end
      OP_AUDIO: begin
        result_o.delay     = delay_audio;
        result_o.drop      = drop_audio;
        result_o.other_pts = video_pts_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    video_pts_d  = video_pts_q;
    audio_pts_d  = audio_pts_q;
    audio_tick_d = audio_tick_q;
    free_tick_d  = free_tick_q;
    if (fire_i) begin
      unique case (item_i.operation)
        OP_VIDEO: begin
          video_pts_d = item_i.pts;
          if (!cfg_i.sync_mode && stale) begin
            free_tick_d = item_i.now;
          end
        end
        OP_AUDIO: begin
          audio_pts_d  = item_i.pts;
          audio_tick_d = item_i.now;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      video_pts_q  <= '0;
      audio_pts_q  <= '0;
      audio_tick_q <= '0;
      free_tick_q  <= '0;
    end else begin
      video_pts_q  <= video_pts_d;
      audio_pts_q  <= audio_pts_d;
      audio_tick_q <= audio_tick_d;
      free_tick_q  <= free_tick_d;
    end
  end

endmodule

[hw/rtl/avsfp_out_reg.sv]
module avsfp_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  avsfp_pkg::out_item_t result_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output avsfp_pkg::out_item_t out_item_o
);
  import avsfp_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign room_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

[hw/rtl/av_sync_frame_pacer_core.sv]
// Path: an input transfer is held in the input register, then its result in the result
// register, from which it goes out on m_axis once the output side is free.
// Throughput: one item per cycle while m_axis is ready, set by the input register
// feeding the decision logic and result register; state updates as each result is registered.
// Reset (rst_ni low, asynchronous): stream state cleared to zero, thresholds back to
// 100 and 2000 ms, audio-master mode, both stages empty.
module av_sync_frame_pacer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: pts_ms[39:0], now_ms[71:40], play_time_ms[81:72], zero pad
  input  logic [avsfp_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: operation
  input  logic                           s_axis_tuser,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: delay_ms[16:0], drop_frame[17], other_pts_ms[57:18], audio_present[58], zero pad
  output logic [avsfp_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [avsfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [avsfp_pkg::ThrW-1:0]     cfg_data_i
);
  import avsfp_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item, stage_item;
  out_item_t result, out_item;
  logic      stage_valid, room, fire;

  assign in_item.operation = op_e'(s_axis_tuser);
  assign in_item.pts       = s_axis_tdata[39:0];
  assign in_item.now       = s_axis_tdata[71:40];
  assign in_item.play      = s_axis_tdata[81:72];

  assign fire = stage_valid && room;

  avsfp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  avsfp_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .pop_i      (fire),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  avsfp_decide u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (stage_item),
    .cfg_i    (cfg),
    .result_o (result)
  );

  avsfp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (result),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata = {5'b0, out_item.audio_present, out_item.other_pts,
                         out_item.drop, out_item.delay};

endmodule

[hw/rtl/avsfp_checker.sv]
module avsfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a dropped frame carries no delay
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17] |-> m_axis_tdata[16:0] == 17'd0)
    else $error("drop with nonzero delay");

  // drop is audio-only, present is video-only
  a_drop_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[17] && m_axis_tdata[58]))
    else $error("drop and audio_present both set");

  // audio_present delays are never negative
  a_present_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[58] |-> !m_axis_tdata[16])
    else $error("negative delay on video frame");

endmodule

bind av_sync_frame_pacer_core avsfp_checker u_avsfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
